// ===== hw/rtl/hlc_pkg.sv =====
`timescale 1ns / 1ps

package hlc_pkg;

   // sizing
   localparam int POS_BITS       = 24;
   localparam int GAIN_FRAC_BITS = 8;

   localparam int GAIN_W    = 12;
   localparam int SLEW_W    = 7;
   localparam int WINDOW_W  = 16;
   localparam int CURRENT_W = 12;
   localparam int TARGET_W  = 24;
   localparam int POWER_W   = 8;
   localparam int MODE_W    = 2;
   localparam int ACC_W     = 32;
   localparam int LAST_W    = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_WINDOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_CURRENT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_TARGET     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE       = 3'd7;

   // mode codes as seen on the result channel
   localparam logic [MODE_W-1:0] MODE_CODE_MANUAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_HOMING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_MOVING = 2'd2;

   // fixed drive levels
   localparam logic signed [POWER_W-1:0] POWER_UP   = 8'sd127;
   localparam logic signed [POWER_W-1:0] POWER_DOWN = -8'sd80;
   localparam logic signed [POWER_W-1:0] POWER_OFF  = 8'sd0;

   typedef enum logic [2:0] {
      MODE_MANUAL = 3'b001,
      MODE_HOMING = 3'b010,
      MODE_MOVING = 3'b100
   } mode_type;

   typedef struct packed {
      logic                        btn_up;
      logic                        btn_down;
      logic                        btn_macro;
      logic [CURRENT_W-1:0]        current_draw;
      logic signed [POS_BITS-1:0]  position;
   } req_payload_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] motor_power;
      logic                      sensor_zero;
      logic                      brake;
      logic [MODE_W-1:0]         mode;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0]          gain_p;
      logic [GAIN_W-1:0]          gain_i;
      logic [GAIN_W-1:0]          gain_d;
      logic [SLEW_W-1:0]          slew_step;
      logic [WINDOW_W-1:0]        integral_window;
      logic [CURRENT_W-1:0]       home_current;
      logic signed [TARGET_W-1:0] home_target;
      logic [WINDOW_W-1:0]        tolerance;
   } cfg_type;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] code;
      unique case (m)
         MODE_HOMING: code = MODE_CODE_HOMING;
         MODE_MOVING: code = MODE_CODE_MOVING;
         default:     code = MODE_CODE_MANUAL;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/hlc_if.sv =====
`timescale 1ns / 1ps

interface hlc_req_if;
   import hlc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       btn_up;
   logic                       btn_down;
   logic                       btn_macro;
   logic [CURRENT_W-1:0]       current_draw;
   logic signed [POS_BITS-1:0] position;

   modport source (output valid, btn_up, btn_down, btn_macro, current_draw, position,
                   input ready);
   modport sink   (input valid, btn_up, btn_down, btn_macro, current_draw, position,
                   output ready);
endinterface

interface hlc_rsp_if;
   import hlc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POWER_W-1:0] motor_power;
   logic                      sensor_zero;
   logic                      brake;
   logic [MODE_W-1:0]         mode;

   modport source (output valid, motor_power, sensor_zero, brake, mode, input ready);
   modport sink   (input valid, motor_power, sensor_zero, brake, mode, output ready);
endinterface

interface hlc_csr_if;
   import hlc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hlc_csr.sv =====
`timescale 1ns / 1ps

module hlc_csr (
   input  logic            clock,
   input  logic            reset,
   hlc_csr_if.sink         csr_chan,
   output hlc_pkg::cfg_type cfg
);
   import hlc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_chan.ready = 1'b1;
   assign write_en       = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_chan.index)
            CSR_GAIN_P:          cfg_in.gain_p          = csr_chan.data[GAIN_W-1:0];
            CSR_GAIN_I:          cfg_in.gain_i          = csr_chan.data[GAIN_W-1:0];
            CSR_GAIN_D:          cfg_in.gain_d          = csr_chan.data[GAIN_W-1:0];
            CSR_SLEW_STEP:       cfg_in.slew_step       = csr_chan.data[SLEW_W-1:0];
            CSR_INTEGRAL_WINDOW: cfg_in.integral_window = csr_chan.data[WINDOW_W-1:0];
            CSR_HOME_CURRENT:    cfg_in.home_current    = csr_chan.data[CURRENT_W-1:0];
            CSR_HOME_TARGET:     cfg_in.home_target     = $signed(csr_chan.data[TARGET_W-1:0]);
            CSR_TOLERANCE:       cfg_in.tolerance       = csr_chan.data[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= GAIN_W'(38);
         cfg_ff.gain_i          <= GAIN_W'(0);
         cfg_ff.gain_d          <= GAIN_W'(256);
         cfg_ff.slew_step       <= SLEW_W'(2);
         cfg_ff.integral_window <= WINDOW_W'(500);
         cfg_ff.home_current    <= CURRENT_W'(2200);
         cfg_ff.home_target     <= TARGET_W'(110);
         cfg_ff.tolerance       <= WINDOW_W'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/hlc_pid_core.sv =====
`timescale 1ns / 1ps

module hlc_pid_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  hlc_pkg::req_payload_type req_data,
   input  hlc_pkg::cfg_type         cfg,
   output hlc_pkg::rsp_payload_type rsp_data
);
   import hlc_pkg::*;

   localparam int ERR_W   = ((POS_BITS > TARGET_W) ? POS_BITS : TARGET_W) + 1;
   localparam int DER_W   = ERR_W + 1;
   localparam int ACCX_W  = ((ACC_W > ERR_W) ? ACC_W : ERR_W) + 1;
   localparam int PROD_P_W = ERR_W + GAIN_W + 1;
   localparam int PROD_I_W = ACC_W + GAIN_W + 1;
   localparam int PROD_D_W = DER_W + GAIN_W + 1;
   localparam int PROD_MAX = (PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W;
   localparam int SUM_W   = PROD_MAX + 2;
   localparam int RAW_W   = SUM_W - GAIN_FRAC_BITS;
   localparam int DIFF_W  = RAW_W + 1;

   localparam logic signed [RAW_W-1:0] PWR_MAX = RAW_W'(127);
   localparam logic signed [RAW_W-1:0] PWR_MIN = RAW_W'(-127);

   // loop state
   mode_type                   mode_ff,        mode_in;
   logic signed [TARGET_W-1:0] target_ff,      target_in;
   logic signed [ERR_W-1:0]    last_error_ff,  last_error_in;
   logic signed [ACC_W-1:0]    error_sum_ff,   error_sum_in;
   logic signed [LAST_W-1:0]   last_output_ff, last_output_in;

   mode_type                   mode_eff;
   logic                       home_done;
   logic signed [ERR_W-1:0]    err;
   logic [ERR_W-1:0]           err_mag;
   logic                       in_window;
   logic                       in_tolerance;
   logic signed [ACCX_W-1:0]   acc_wide;
   logic                       acc_fits;
   logic signed [ACC_W-1:0]    acc_sat;
   logic signed [ACC_W-1:0]    acc_new;
   logic signed [DER_W-1:0]    deriv;
   logic signed [GAIN_W:0]     kp, ki, kd;
   logic signed [PROD_P_W-1:0] prod_p;
   logic signed [PROD_I_W-1:0] prod_i;
   logic signed [PROD_D_W-1:0] prod_d;
   logic signed [SUM_W-1:0]    pid_sum;
   logic signed [RAW_W-1:0]    raw;
   logic signed [DIFF_W-1:0]   rise;
   logic signed [DIFF_W-1:0]   slew_s;
   logic signed [RAW_W-1:0]    raw_lim;
   logic                       last_fits;
   logic signed [LAST_W-1:0]   last_sat;
   logic signed [RAW_W-1:0]    pwr_wide;

   always_comb begin
      // macro press starts homing from manual, a direction button always wins
      mode_eff = mode_ff;
      if (req_data.btn_macro && (mode_ff == MODE_MANUAL))
         mode_eff = MODE_HOMING;
      if ((req_data.btn_up || req_data.btn_down) && (mode_eff != MODE_MANUAL))
         mode_eff = MODE_MANUAL;

      home_done = req_data.current_draw > cfg.home_current;

      // pid datapath
      err     = ERR_W'(target_ff) - ERR_W'(req_data.position);
      err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      in_window    = err_mag < ERR_W'(cfg.integral_window);
      in_tolerance = err_mag < ERR_W'(cfg.tolerance);

      acc_wide = ACCX_W'(error_sum_ff) + ACCX_W'(err);
      acc_fits = (&acc_wide[ACCX_W-1:ACC_W-1]) || !(|acc_wide[ACCX_W-1:ACC_W-1]);
      acc_sat  = acc_fits ? acc_wide[ACC_W-1:0]
                          : {acc_wide[ACCX_W-1], {(ACC_W-1){~acc_wide[ACCX_W-1]}}};
      acc_new  = in_window ? acc_sat : '0;

      deriv = DER_W'(err) - DER_W'(last_error_ff);

      kp = $signed({1'b0, cfg.gain_p});
      ki = $signed({1'b0, cfg.gain_i});
      kd = $signed({1'b0, cfg.gain_d});
      prod_p = err * kp;
      prod_i = acc_new * ki;
      prod_d = deriv * kd;
      pid_sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
      raw     = RAW_W'(pid_sum >>> GAIN_FRAC_BITS);

      // only a rising positive drive is slew limited
      rise    = DIFF_W'(raw) - DIFF_W'(last_output_ff);
      slew_s  = DIFF_W'($signed({1'b0, cfg.slew_step}));
      raw_lim = raw;
      if (!raw[RAW_W-1] && (raw != '0) && (rise > slew_s))
         raw_lim = RAW_W'(last_output_ff) + RAW_W'($signed({1'b0, cfg.slew_step}));

      last_fits = (&raw_lim[RAW_W-1:LAST_W-1]) || !(|raw_lim[RAW_W-1:LAST_W-1]);
      last_sat  = last_fits ? raw_lim[LAST_W-1:0]
                            : {raw_lim[RAW_W-1], {(LAST_W-1){~raw_lim[RAW_W-1]}}};
      if (raw_lim > PWR_MAX)
         pwr_wide = PWR_MAX;
      else if (raw_lim < PWR_MIN)
         pwr_wide = PWR_MIN;
      else
         pwr_wide = raw_lim;

      // next state and result
      mode_in        = mode_eff;
      target_in      = target_ff;
      last_error_in  = last_error_ff;
      error_sum_in   = error_sum_ff;
      last_output_in = last_output_ff;
      rsp_data.motor_power = POWER_OFF;
      rsp_data.sensor_zero = 1'b0;
      rsp_data.brake       = 1'b0;

      unique case (mode_eff)
         MODE_HOMING: begin
            rsp_data.motor_power = POWER_DOWN;
            if (home_done) begin
               rsp_data.motor_power = POWER_OFF;
               rsp_data.sensor_zero = 1'b1;
               target_in     = cfg.home_target;
               last_error_in = '0;
               error_sum_in  = '0;
               mode_in       = MODE_MOVING;
            end
         end
         MODE_MOVING: begin
            error_sum_in   = acc_new;
            last_error_in  = err;
            last_output_in = last_sat;
            rsp_data.motor_power = pwr_wide[POWER_W-1:0];
            if (in_tolerance) begin
               rsp_data.motor_power = POWER_OFF;
               rsp_data.brake       = 1'b1;
               mode_in              = MODE_MANUAL;
            end
         end
         default: begin
            if (req_data.btn_up)
               rsp_data.motor_power = POWER_UP;
            else if (req_data.btn_down)
               rsp_data.motor_power = POWER_DOWN;
         end
      endcase

      rsp_data.mode = mode_code(mode_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MANUAL;
         target_ff      <= '0;
         last_error_ff  <= '0;
         error_sum_ff   <= '0;
         last_output_ff <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         target_ff      <= target_in;
         last_error_ff  <= last_error_in;
         error_sum_ff   <= error_sum_in;
         last_output_ff <= last_output_in;
      end
   end

endmodule

// ===== hw/rtl/homing_pid_lift_controller_top.sv =====
`timescale 1ns / 1ps
// a result enters the response register as its request leaves the request register
// throughput: one transaction per cycle unless stalled; the control tick is one pass of logic
// between the request register and the response register, with the loop state updated
// in the same cycle; a stalled response still lets one more request into the request register
// reset (synchronous, active high) returns to manual mode, clears the loop state and
// empties both registers; the configuration registers return to their documented defaults
module homing_pid_lift_controller_top (
   input  logic       clock,
   input  logic       reset,
   hlc_req_if.sink    req_chan,
   hlc_rsp_if.source  rsp_chan,
   hlc_csr_if.sink    csr_chan
);
   import hlc_pkg::*;

   // request register
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_data_ff,  req_data_in;
   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   cfg_type         cfg;
   logic            req_accept;
   logic            step_en;

   // configuration registers, always ready
   hlc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // a held request moves on whenever the response register is free or being emptied
   assign step_en        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || step_en;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      req_data_in.btn_up       = req_chan.btn_up;
      req_data_in.btn_down     = req_chan.btn_down;
      req_data_in.btn_macro    = req_chan.btn_macro;
      req_data_in.current_draw = req_chan.current_draw;
      req_data_in.position     = req_chan.position;
   end

   always_comb begin
      if (req_accept)
         req_valid_in = 1'b1;
      else if (step_en)
         req_valid_in = 1'b0;
      else
         req_valid_in = req_valid_ff;

      if (step_en)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   // mode logic, pid datapath and the loop state it carries from tick to tick
   hlc_pid_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req_data (req_data_ff),
      .cfg      (cfg),
      .rsp_data (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept)
         req_data_ff <= req_data_in;
      if (step_en)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.motor_power = rsp_data_ff.motor_power;
   assign rsp_chan.sensor_zero = rsp_data_ff.sensor_zero;
   assign rsp_chan.brake       = rsp_data_ff.brake;
   assign rsp_chan.mode        = rsp_data_ff.mode;

   // a tick never both finishes homing and finishes a move
   a_pulse_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.sensor_zero && rsp_data_ff.brake))
      else $error("sensor zero pulse and brake in the same transaction");

   // homing completion hands over to the move
   a_home_to_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.sensor_zero) |->
         (rsp_data_ff.mode == MODE_CODE_MOVING && rsp_data_ff.motor_power == POWER_OFF))
      else $error("homing completion without move mode and zero drive");

   // a finished move stops the motor and drops back to manual
   a_brake_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.brake) |->
         (rsp_data_ff.mode == MODE_CODE_MANUAL && rsp_data_ff.motor_power == POWER_OFF))
      else $error("brake without manual mode and zero drive");

   // drive clamp is symmetric, the most negative code never appears
   a_power_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.motor_power != -8'sd128))
      else $error("motor_power outside clamp");

   // a request held in the register always advances when the response side is free
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("request register did not advance");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import hlc_pkg::*;

   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     HOLD_CYCLES   = 200;
   localparam int     SETTLE_CYCLES = 4;
   localparam int     IDLE_PERCENT  = 12;
   localparam longint SUM_MAX  = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint SUM_MIN  = -SUM_MAX - 1;
   localparam longint LAST_MAX = (longint'(1) << (LAST_W - 1)) - 1;
   localparam longint LAST_MIN = -LAST_MAX - 1;
   localparam longint POS_MAX  = (longint'(1) << (POS_BITS - 1)) - 1;
   localparam longint POS_MIN  = -POS_MAX - 1;
   localparam int     CURRENT_MAX = (1 << CURRENT_W) - 1;

   logic clock;
   logic reset;

   hlc_req_if req_if ();
   hlc_rsp_if rsp_if ();
   hlc_csr_if csr_if ();

   homing_pid_lift_controller_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ticks waiting to be offered, and replies the lift model has worked out
   req_payload_type pending_ticks[$];
   rsp_payload_type expected_replies[$];

   int   mismatch_count;
   int   cycle_count;
   logic req_taken;
   logic steady;        // when set neither side idles
   int   holds_asked;   // bumped by the stimulus to ask for a long receiver hold-off
   int   holds_begun;
   int   hold_left;

   // settings the stimulus is planning around (mirrors what was last written)
   cfg_type plan_cfg;

   // lift model state and its own copy of the settings
   cfg_type           model_cfg;
   logic [MODE_W-1:0] lift_mode;
   longint            last_err;
   longint            err_sum;
   longint            last_drive;
   longint            move_target;

   function automatic cfg_type reset_settings();
      cfg_type c;
      c.gain_p          = 12'd38;
      c.gain_i          = 12'd0;
      c.gain_d          = 12'd256;
      c.slew_step       = 7'd2;
      c.integral_window = 16'd500;
      c.home_current    = 12'd2200;
      c.home_target     = 24'sd110;
      c.tolerance       = 16'd5;
      return c;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // one control tick of the lift: mode changes, homing, then the pid move
   task automatic predict_lift_tick(input req_payload_type t, output rsp_payload_type r);
      longint err;
      longint deriv;
      longint raw;
      longint drive;
      logic   rst_pulse;
      logic   brake_pulse;
      drive       = 0;
      rst_pulse   = 1'b0;
      brake_pulse = 1'b0;

      // macro only starts homing from manual; any direction button aborts a macro
      if (t.btn_macro && lift_mode == MODE_CODE_MANUAL)
         lift_mode = MODE_CODE_HOMING;
      if ((t.btn_up || t.btn_down) && lift_mode != MODE_CODE_MANUAL)
         lift_mode = MODE_CODE_MANUAL;

      case (lift_mode)
         MODE_CODE_MANUAL: begin
            drive = t.btn_up ? longint'(POWER_UP)
                  : (t.btn_down ? longint'(POWER_DOWN) : longint'(POWER_OFF));
         end
         MODE_CODE_HOMING: begin
            drive = longint'(POWER_DOWN);
            if (t.current_draw > model_cfg.home_current) begin
               // hard stop reached: zero the sensor and start the move
               drive       = longint'(POWER_OFF);
               rst_pulse   = 1'b1;
               move_target = longint'($signed(model_cfg.home_target));
               last_err    = 0;
               err_sum     = 0;
               lift_mode   = MODE_CODE_MOVING;
            end
         end
         default: begin
            err = move_target - longint'($signed(t.position));
            // integral only builds close to the target
            if (magnitude(err) < longint'(model_cfg.integral_window))
               err_sum = clip(err_sum + err, SUM_MIN, SUM_MAX);
            else
               err_sum = 0;
            deriv    = err - last_err;
            last_err = err;
            raw = (err * longint'(model_cfg.gain_p) + err_sum * longint'(model_cfg.gain_i)
                   + deriv * longint'(model_cfg.gain_d)) >>> GAIN_FRAC_BITS;
            // slew limit on a rising positive drive
            if (raw > 0 && raw - last_drive > longint'(model_cfg.slew_step))
               raw = last_drive + longint'(model_cfg.slew_step);
            last_drive = clip(raw, LAST_MIN, LAST_MAX);
            drive      = clip(raw, -longint'(POWER_UP), longint'(POWER_UP));
            if (magnitude(err) < longint'(model_cfg.tolerance)) begin
               drive       = longint'(POWER_OFF);
               brake_pulse = 1'b1;
               lift_mode   = MODE_CODE_MANUAL;
            end
         end
      endcase

      r.motor_power = drive[POWER_W-1:0];
      r.sensor_zero = rst_pulse;
      r.brake       = brake_pulse;
      r.mode        = lift_mode;
   endtask

   // driver: offers queued ticks, idling now and then, changes on the falling edge
   always @(negedge clock) begin : tick_driver
      req_payload_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            nxt = pending_ticks.pop_front();
            req_if.valid        <= 1'b1;
            req_if.btn_up       <= nxt.btn_up;
            req_if.btn_down     <= nxt.btn_down;
            req_if.btn_macro    <= nxt.btn_macro;
            req_if.current_draw <= nxt.current_draw;
            req_if.position     <= nxt.position;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure, plus a long hold-off when the stimulus asks for one
   always @(negedge clock) begin : reply_sink
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         holds_begun  <= 0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (holds_begun != holds_asked) begin
         holds_begun  <= holds_begun + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor: everything is sampled on the rising edge
   always @(posedge clock) begin : reply_monitor
      req_payload_type t;
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         model_cfg   = reset_settings();
         lift_mode   = MODE_CODE_MANUAL;
         last_err    = 0;
         err_sum     = 0;
         last_drive  = 0;
         move_target = 0;
         req_taken  <= 1'b0;
      end else begin
         // register write transaction
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_GAIN_P:          model_cfg.gain_p          = csr_if.data[GAIN_W-1:0];
               CSR_GAIN_I:          model_cfg.gain_i          = csr_if.data[GAIN_W-1:0];
               CSR_GAIN_D:          model_cfg.gain_d          = csr_if.data[GAIN_W-1:0];
               CSR_SLEW_STEP:       model_cfg.slew_step       = csr_if.data[SLEW_W-1:0];
               CSR_INTEGRAL_WINDOW: model_cfg.integral_window = csr_if.data[WINDOW_W-1:0];
               CSR_HOME_CURRENT:    model_cfg.home_current    = csr_if.data[CURRENT_W-1:0];
               CSR_HOME_TARGET:     model_cfg.home_target     = csr_if.data[TARGET_W-1:0];
               CSR_TOLERANCE:       model_cfg.tolerance       = csr_if.data[WINDOW_W-1:0];
               default: ;
            endcase
         end

         // reply transaction: check against the oldest expectation first
         if (rsp_if.valid && rsp_if.ready) begin
            got.motor_power = rsp_if.motor_power;
            got.sensor_zero = rsp_if.sensor_zero;
            got.brake       = rsp_if.brake;
            got.mode        = rsp_if.mode;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply transaction with nothing expected");
            end else begin
               want = expected_replies.pop_front();
               if (got.motor_power !== want.motor_power)
                  report_mismatch($sformatf("motor_power got %0d want %0d",
                                            got.motor_power, want.motor_power));
               if (got.sensor_zero !== want.sensor_zero)
                  report_mismatch($sformatf("sensor_zero got %b want %b",
                                            got.sensor_zero, want.sensor_zero));
               if (got.brake !== want.brake)
                  report_mismatch($sformatf("brake got %b want %b", got.brake, want.brake));
               if (got.mode !== want.mode)
                  report_mismatch($sformatf("mode got %0d want %0d", got.mode, want.mode));
            end
         end

         // request transaction: run the lift model on it
         if (req_if.valid && req_if.ready) begin
            t.btn_up       = req_if.btn_up;
            t.btn_down     = req_if.btn_down;
            t.btn_macro    = req_if.btn_macro;
            t.current_draw = req_if.current_draw;
            t.position     = req_if.position;
            predict_lift_tick(t, want);
            expected_replies.insert(expected_replies.size(), want);
         end
         req_taken <= req_if.valid && req_if.ready;
      end
   end

   // watchdog
   always @(posedge clock) begin : run_watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // queue one tick, with the position clipped to the sensor range
   task automatic push_tick(input bit up, input bit down, input bit macro, input int cur,
                            input longint pos);
      req_payload_type t;
      longint p;
      p = clip(pos, POS_MIN, POS_MAX);
      t.btn_up       = up;
      t.btn_down     = down;
      t.btn_macro    = macro;
      t.current_draw = cur[CURRENT_W-1:0];
      t.position     = p[POS_BITS-1:0];
      pending_ticks.insert(pending_ticks.size(), t);
   endtask

   function automatic longint random_sign();
      return ($urandom_range(1) == 1) ? 1 : -1;
   endfunction

   function automatic longint random_position();
      return longint'($signed(POS_BITS'($urandom)));
   endfunction

   // one register write transaction; valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic program_settings(input cfg_type c);
      write_reg(CSR_GAIN_P,          CSR_DATA_W'(c.gain_p));
      write_reg(CSR_GAIN_I,          CSR_DATA_W'(c.gain_i));
      write_reg(CSR_GAIN_D,          CSR_DATA_W'(c.gain_d));
      write_reg(CSR_SLEW_STEP,       CSR_DATA_W'(c.slew_step));
      write_reg(CSR_INTEGRAL_WINDOW, CSR_DATA_W'(c.integral_window));
      write_reg(CSR_HOME_CURRENT,    CSR_DATA_W'(c.home_current));
      write_reg(CSR_HOME_TARGET,     CSR_DATA_W'(c.home_target));
      write_reg(CSR_TOLERANCE,       CSR_DATA_W'(c.tolerance));
      @(negedge clock);
      csr_if.valid <= 1'b0;
      plan_cfg = c;
   endtask

   // wait until every tick is through and every reply checked
   task automatic drain_block();
      while (pending_ticks.size() != 0 || req_if.valid || expected_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.gain_p          = GAIN_W'($urandom_range(1) ? $urandom_range(4095) : $urandom_range(300));
      c.gain_i          = GAIN_W'($urandom_range(1) ? $urandom_range(4095) : $urandom_range(20));
      c.gain_d          = GAIN_W'($urandom_range(4095));
      c.slew_step       = SLEW_W'($urandom_range(127));
      c.integral_window = WINDOW_W'($urandom_range(1) ? $urandom_range(65535)
                                                      : $urandom_range(1000));
      c.home_current    = CURRENT_W'($urandom_range(4095));
      c.home_target     = TARGET_W'($urandom);
      c.tolerance       = WINDOW_W'($urandom_range(1) ? $urandom_range(65535)
                                                      : $urandom_range(50));
      return c;
   endfunction

   // mostly complete homing-and-move cycles with random content, the rest noise
   task automatic queue_random_traffic(input int count);
      int     queued;
      int     hc;
      int     tol;
      int     win;
      int     n;
      int     kind;
      bit     aborted;
      longint target;
      longint err;
      queued = 0;
      while (queued < count) begin
         hc     = int'(plan_cfg.home_current);
         tol    = int'(plan_cfg.tolerance);
         win    = int'(plan_cfg.integral_window);
         target = longint'($signed(plan_cfg.home_target));
         kind   = $urandom_range(99);
         if (kind < 70) begin
            // macro press, a few homing ticks at or below the threshold, then the hard stop
            push_tick(0, 0, 1, $urandom_range(hc, 0), random_position());
            n = $urandom_range(4);
            repeat (n) push_tick(0, 0, $urandom_range(7) == 0, $urandom_range(hc, 0),
                                 random_position());
            if (hc < CURRENT_MAX)
               push_tick(0, 0, 0, $urandom_range(CURRENT_MAX, hc + 1), random_position());
            queued += n + 2;
            // the move: error closes in on the target, sometimes cut short by a button
            err = ($urandom_range(1) == 1) ? longint'($urandom_range(win)) * random_sign()
                : (longint'($signed($urandom)) >>> $urandom_range(31, 7));
            n = $urandom_range(20, 1);
            aborted = 0;
            for (int k = 0; k < n && !aborted; k++) begin
               if ($urandom_range(99) < 5) begin
                  push_tick(1'($urandom_range(1)), 1, 0, $urandom_range(CURRENT_MAX),
                            random_position());
                  aborted = 1;
               end else begin
                  push_tick(0, 0, $urandom_range(9) == 0, $urandom_range(CURRENT_MAX),
                            target - err);
                  err = err / 2 + longint'($urandom_range(16)) - 8;
               end
               queued++;
            end
            if (!aborted && tol > 0) begin
               push_tick(0, 0, 0, $urandom_range(CURRENT_MAX),
                         target - longint'($urandom_range(tol - 1)) * random_sign());
               queued++;
            end
         end else if (kind < 85) begin
            // fully random ticks
            n = $urandom_range(4, 1);
            repeat (n) push_tick($urandom_range(3) == 0, $urandom_range(3) == 0,
                                 $urandom_range(3) == 0, $urandom_range(CURRENT_MAX),
                                 random_position());
            queued += n;
         end else begin
            // broken cycle: macro then a direction button part way through homing
            push_tick(0, 0, 1, $urandom_range(CURRENT_MAX), random_position());
            push_tick(0, 0, 0, $urandom_range(hc, 0), random_position());
            push_tick(1'($urandom_range(1)), 1, 1'($urandom_range(1)),
                      $urandom_range(CURRENT_MAX), random_position());
            queued += 3;
         end
      end
   endtask

   task automatic run_phase(input cfg_type c, input int count);
      program_settings(c);
      queue_random_traffic(count);
      drain_block();
   endtask

   initial begin : stimulus
      cfg_type c;
      mismatch_count      = 0;
      cycle_count         = 0;
      steady              = 1'b0;
      holds_asked         = 0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.btn_up       = 1'b0;
      req_if.btn_down     = 1'b0;
      req_if.btn_macro    = 1'b0;
      req_if.current_draw = '0;
      req_if.position     = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.data         = '0;
      plan_cfg            = reset_settings();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed ticks on the reset settings
      push_tick(0, 0, 0, 0, 0);                      // manual, no button
      push_tick(1, 0, 0, CURRENT_MAX, POS_MAX);      // up
      push_tick(0, 1, 0, 0, POS_MIN);                // down
      push_tick(1, 1, 0, 0, 0);                      // both buttons, up wins
      push_tick(1, 0, 1, 0, 0);                      // macro with a button stays manual
      push_tick(0, 1, 1, 0, 0);
      push_tick(0, 0, 1, 0, 0);                      // macro starts homing
      push_tick(0, 0, 0, 2200, 0);                   // current at threshold, not above
      push_tick(0, 0, 1, 100, 0);                    // macro while homing is ignored
      push_tick(0, 0, 0, 2201, 0);                   // hard stop, sensor zeroed
      push_tick(0, 0, 0, 0, 0);                      // move, slew limited
      push_tick(0, 0, 1, 0, POS_MIN);                // far below, integral outside window
      push_tick(0, 0, 0, 0, POS_MAX);                // far above, negative clamp
      push_tick(0, 0, 0, 0, 108);                    // within tolerance, brake
      push_tick(0, 0, 1, 0, 0);
      push_tick(0, 1, 0, 0, 0);                      // button aborts homing
      push_tick(0, 0, 1, 0, 0);
      push_tick(0, 0, 0, CURRENT_MAX, 0);
      push_tick(0, 0, 0, 0, 400);                    // inside the window
      push_tick(1, 0, 0, 0, 0);                      // button aborts the move
      queue_random_traffic(300);
      drain_block();

      // all settings at their low end, most negative target
      c = '0;
      c.home_target = TARGET_W'(POS_MIN);
      run_phase(c, 250);

      // all settings at their high end, bar a threshold that homing can still beat
      c.gain_p          = '1;
      c.gain_i          = '1;
      c.gain_d          = '1;
      c.slew_step       = '1;
      c.integral_window = '1;
      c.home_current    = CURRENT_W'(CURRENT_MAX - 1);
      c.home_target     = TARGET_W'(POS_MAX);
      c.tolerance       = '1;
      run_phase(c, 250);

      // threshold at full scale: homing can never finish
      c = random_settings();
      c.home_current = '1;
      run_phase(c, 100);

      // random settings; the first phase holds the receiver off so the block backs up
      for (int ph = 0; ph < 4; ph++) begin
         c = random_settings();
         program_settings(c);
         if (ph == 0)
            holds_asked++;
         queue_random_traffic(200);
         drain_block();
      end

      // large integral build-up both ways, with no idling on either side
      c.gain_p          = 12'd1;
      c.gain_i          = '1;
      c.gain_d          = '0;
      c.slew_step       = '1;
      c.integral_window = '1;
      c.home_current    = '0;
      c.home_target     = '0;
      c.tolerance       = '0;
      program_settings(c);
      steady = 1'b1;
      push_tick(0, 0, 1, 0, 0);
      push_tick(0, 0, 0, 1, 0);
      repeat (40) push_tick(0, 0, 0, 0, -65534);
      push_tick(0, 0, 0, 0, -70000);                 // outside the window, integral cleared
      repeat (40) push_tick(0, 0, 0, 0, 65534);
      push_tick(0, 1, 0, 0, 0);
      drain_block();
      steady = 1'b0;

      // final drain, then the verdict
      drain_block();
      repeat (8) @(negedge clock);
      if (expected_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hlc_pkg.sv
hw/rtl/hlc_if.sv
hw/rtl/hlc_csr.sv
hw/rtl/hlc_pid_core.sv
hw/rtl/homing_pid_lift_controller_top.sv
tb/sv/tb.sv
